@@ sv/rtp_pkg.sv @@
package rtp_pkg;

  localparam int unsigned SYM_W       = 8;
  localparam int unsigned TONE_W      = 8;
  localparam int unsigned DUR_W       = 13;
  localparam int unsigned WHOLE_W     = 12;
  localparam int unsigned IDX_W       = 6;
  localparam int unsigned CFG_DATA_W  = 12;
  localparam int unsigned OUT_TDATA_W = 32;
  localparam int unsigned OUT_PAD_W   = OUT_TDATA_W - TONE_W - DUR_W - IDX_W;
  localparam int unsigned QDEPTH      = 2;
  localparam int unsigned STEP_W      = $clog2(WHOLE_W);

  localparam logic [DUR_W-1:0]   DUR_MAX       = 13'd6142;
  localparam logic [TONE_W-1:0]  BASE_TONE_RST = 8'd36;
  localparam logic [WHOLE_W-1:0] WHOLE_RST     = 12'd800;
  localparam logic [TONE_W-1:0]  UNKNOWN_OFS   = 8'd13;

  localparam logic [SYM_W-1:0] CH_SPACE = 8'h20;
  localparam logic [SYM_W-1:0] CH_SHARP = 8'h23;
  localparam logic [SYM_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [SYM_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [SYM_W-1:0] CH_ONE   = 8'h31;
  localparam logic [SYM_W-1:0] CH_NINE  = 8'h39;
  localparam logic [SYM_W-1:0] CH_LA    = 8'h61;
  localparam logic [SYM_W-1:0] CH_LB    = 8'h62;
  localparam logic [SYM_W-1:0] CH_LC    = 8'h63;
  localparam logic [SYM_W-1:0] CH_LD    = 8'h64;
  localparam logic [SYM_W-1:0] CH_LE    = 8'h65;
  localparam logic [SYM_W-1:0] CH_LF    = 8'h66;
  localparam logic [SYM_W-1:0] CH_LG    = 8'h67;
  localparam logic [SYM_W-1:0] CH_LZ    = 8'h7A;

  typedef enum logic [1:0] {
    PH_LEN1,
    PH_LEN2,
    PH_TONE,
    PH_OCT
  } phase_e;

  typedef enum logic [1:0] {
    CMD_START,
    CMD_LEN,
    CMD_NOTE
  } cmd_kind_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_FIN
  } back_state_e;

  typedef enum logic {
    REG_BASE_TONE = 1'b0,
    REG_WHOLE_DUR = 1'b1
  } reg_idx_e;

  typedef struct packed {
    cmd_kind_e          kind;
    logic [SYM_W-1:0]   value;
    logic               dotted;
    logic [WHOLE_W-1:0] whole;
  } cmd_t;

  function automatic logic [TONE_W-1:0] letter_offset(input logic [SYM_W-1:0] c);
    logic [TONE_W-1:0] ofs;
    case (c)
      CH_LC:   ofs = 8'd0;
      CH_LD:   ofs = 8'd2;
      CH_LE:   ofs = 8'd4;
      CH_LF:   ofs = 8'd5;
      CH_LG:   ofs = 8'd7;
      CH_LA:   ofs = 8'd9;
      CH_LB:   ofs = 8'd11;
      default: ofs = UNKNOWN_OFS;
    endcase
    return ofs;
  endfunction

endpackage

@@ sv/rtp_queue.sv @@
module rtp_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  rtp_pkg::cmd_t push_cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output rtp_pkg::cmd_t head_o
);
  import rtp_pkg::*;

  localparam int unsigned PTR_W = $clog2(QDEPTH);
  localparam int unsigned CNT_W = $clog2(QDEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QDEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QDEPTH);

  cmd_t             entries_q [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == FULL_CNT);
  assign valid_o = (count_q != '0);
  assign head_o  = entries_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

@@ sv/rtp_front.sv @@
module rtp_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  logic [rtp_pkg::SYM_W-1:0]   symbol_i,
  input  logic                        start_i,
  input  logic [rtp_pkg::TONE_W-1:0]  base_tone_i,
  input  logic [rtp_pkg::WHOLE_W-1:0] whole_i,
  output logic                        push_o,
  output rtp_pkg::cmd_t               cmd_o
);
  import rtp_pkg::*;

  phase_e            phase_q, phase_d;
  logic [SYM_W-1:0]  first_q, first_d;
  logic [TONE_W-1:0] tone_q, tone_d;

  phase_e            ph, ph_rest;
  logic [SYM_W-1:0]  first;
  logic [TONE_W-1:0] tone;
  logic              is_digit, is_dot, is_letter, go_on;
  logic [SYM_W-1:0]  first_num, len1_val, len2_val, oct_x;
  logic [TONE_W-1:0] oct_add, oct_tone;

  assign ph    = start_i ? PH_LEN1 : phase_q;
  assign first = start_i ? '0 : first_q;
  assign tone  = start_i ? base_tone_i : tone_q;

  assign is_digit  = (symbol_i >= CH_ZERO) && (symbol_i <= CH_NINE);
  assign is_dot    = (symbol_i == CH_DOT);
  assign is_letter = (symbol_i >= CH_LA) && (symbol_i <= CH_LZ);

  assign first_num = first - CH_ZERO;
  assign len1_val  = first_num;
  assign len2_val  = {first_num[4:0], 3'b000} + {first_num[6:0], 1'b0} + (symbol_i - CH_ZERO);
  assign oct_x     = symbol_i - CH_ONE;
  assign oct_add   = {oct_x[4:0], 3'b000} + {oct_x[5:0], 2'b00};
  assign oct_tone  = tone + oct_add;

  always_comb begin
    phase_d = phase_q;
    first_d = first_q;
    tone_d  = tone_q;
    push_o  = 1'b0;
    cmd_o   = '{kind: CMD_START, value: '0, dotted: 1'b0, whole: whole_i};
    ph_rest = ph;
    go_on   = 1'b1;
    if (accept_i) begin
      phase_d = ph;
      first_d = first;
      tone_d  = tone;
      if (start_i) begin
        push_o = 1'b1;
      end
      if (ph == PH_LEN2) begin
        push_o     = 1'b1;
        cmd_o.kind = CMD_LEN;
        phase_d    = PH_TONE;
        ph_rest    = PH_TONE;
        if (is_digit) begin
          cmd_o.value = len2_val;
          go_on       = 1'b0;
        end else begin
          cmd_o.value  = len1_val;
          cmd_o.dotted = is_dot;
          go_on        = !is_dot;
        end
      end
      if (go_on) begin
        if (symbol_i == CH_SPACE) begin
          phase_d = PH_LEN1;
          tone_d  = base_tone_i;
        end else begin
          case (ph_rest)
            PH_LEN1: begin
              first_d = symbol_i;
              phase_d = PH_LEN2;
            end
            PH_TONE: begin
              if (symbol_i == CH_SHARP) begin
                tone_d = tone + 1'b1;
              end else if (is_letter) begin
                tone_d  = tone + letter_offset(symbol_i);
                phase_d = PH_OCT;
              end
            end
            PH_OCT: begin
              tone_d      = oct_tone;
              push_o      = 1'b1;
              cmd_o.kind  = CMD_NOTE;
              cmd_o.value = oct_tone;
            end
            default: ;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_LEN1;
      first_q <= '0;
      tone_q  <= BASE_TONE_RST;
    end else begin
      phase_q <= phase_d;
      first_q <= first_d;
      tone_q  <= tone_d;
    end
  end

endmodule

@@ sv/rtp_back.sv @@
module rtp_back #(
  parameter int unsigned NOTE_DEPTH = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cmd_valid_i,
  input  rtp_pkg::cmd_t              cmd_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [rtp_pkg::TONE_W-1:0] tone_o,
  output logic [rtp_pkg::DUR_W-1:0]  duration_o,
  output logic [rtp_pkg::IDX_W-1:0]  note_index_o,
  output logic                       length_error_o
);
  import rtp_pkg::*;

  localparam int unsigned CNT_W = $clog2(NOTE_DEPTH);
  localparam logic [CNT_W-1:0]  CNT_LAST  = CNT_W'(NOTE_DEPTH - 1);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(WHOLE_W - 1);

  back_state_e        state_q, state_d;
  logic [DUR_W-1:0]   dur_q, dur_d;
  logic               err_q, err_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [SYM_W-1:0]   divisor_q, divisor_d;
  logic [SYM_W-1:0]   rem_q, rem_d;
  logic [WHOLE_W-1:0] quo_q, quo_d;
  logic [STEP_W-1:0]  step_q, step_d;
  logic               dotted_q, dotted_d;
  logic               out_valid_q, out_valid_d;
  logic               load_out;

  logic [SYM_W:0]        rem_sh, rem_sub;
  logic                  fits;
  logic                  out_free;
  logic [DUR_W-1:0]      zero_dur, fin_dur;
  logic [CNT_W+IDX_W-1:0] idx_ext;

  assign rem_sh   = {rem_q, quo_q[WHOLE_W-1]};
  assign rem_sub  = rem_sh - {1'b0, divisor_q};
  assign fits     = (rem_sh >= {1'b0, divisor_q});
  assign out_free = !out_valid_q || out_ready_i;
  assign zero_dur = {1'b0, cmd_i.whole}
                  + (cmd_i.dotted ? {2'b00, cmd_i.whole[WHOLE_W-1:1]} : '0);
  assign fin_dur  = {1'b0, quo_q} + (dotted_q ? {2'b00, quo_q[WHOLE_W-1:1]} : '0);
  assign idx_ext  = {{IDX_W{1'b0}}, cnt_q};

  always_comb begin
    state_d     = state_q;
    dur_d       = dur_q;
    err_d       = err_q;
    cnt_d       = cnt_q;
    divisor_d   = divisor_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    step_d      = step_q;
    dotted_d    = dotted_q;
    pop_o       = 1'b0;
    load_out    = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.kind)
            CMD_START: begin
              pop_o = 1'b1;
              dur_d = '0;
              err_d = 1'b0;
              cnt_d = '0;
            end
            CMD_LEN: begin
              pop_o = 1'b1;
              if (cmd_i.value == '0) begin
                dur_d = zero_dur;
                err_d = 1'b1;
              end else begin
                divisor_d = cmd_i.value;
                rem_d     = '0;
                quo_d     = cmd_i.whole;
                step_d    = STEP_LAST;
                dotted_d  = cmd_i.dotted;
                state_d   = BK_DIV;
              end
            end
            CMD_NOTE: begin
              if (out_free) begin
                pop_o       = 1'b1;
                load_out    = 1'b1;
                out_valid_d = 1'b1;
                cnt_d       = (cnt_q == CNT_LAST) ? '0 : cnt_q + 1'b1;
              end
            end
            default: pop_o = 1'b1;
          endcase
        end
      end
      BK_DIV: begin
        rem_d  = fits ? rem_sub[SYM_W-1:0] : rem_sh[SYM_W-1:0];
        quo_d  = {quo_q[WHOLE_W-2:0], fits};
        step_d = step_q - 1'b1;
        if (step_q == '0) begin
          state_d = BK_FIN;
        end
      end
      BK_FIN: begin
        dur_d   = fin_dur;
        err_d   = 1'b0;
        state_d = BK_IDLE;
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      dur_q       <= '0;
      err_q       <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      dur_q       <= dur_d;
      err_q       <= err_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    divisor_q <= divisor_d;
    rem_q     <= rem_d;
    quo_q     <= quo_d;
    step_q    <= step_d;
    dotted_q  <= dotted_d;
    if (load_out) begin
      tone_o         <= cmd_i.value;
      duration_o     <= dur_q;
      note_index_o   <= idx_ext[IDX_W-1:0];
      length_error_o <= err_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ sv/ringtone_text_note_parser_unit.sv @@
// Channel   Dir  Request content
// s_axis    in   tdata: symbol[7:0]; tuser: start_of_tune
// m_axis    out  tdata: tone[7:0], duration[20:8], note_index[26:21], zero[31:27];
//                tuser: length_error
// cfg       in   cfg_index_i: register (0 base_tone, 1 whole_duration); cfg_data_i: value
//
// A character is taken while the command queue (two entries) has room.
// A note leaves the back end once the output is free; a nonzero length goes there through
// load, 12 steps of the restoring divider and finish, a zero length sets the length error.
// Reset is asynchronous and needs no clearing pass; config writes are taken every cycle.
// A stalled m_axis holds its request; the front keeps going until the queue fills.
module ringtone_text_note_parser_unit #(
  parameter int unsigned NOTE_DEPTH = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [7:0]                          s_axis_tdata,  // symbol[7:0]
  input  logic                                s_axis_tuser,  // start_of_tune
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [rtp_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,  // tone, duration, note_index
  output logic                                m_axis_tuser,  // length_error
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic                                cfg_index_i,
  input  logic [rtp_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import rtp_pkg::*;

  logic [TONE_W-1:0]  base_tone_q;
  logic [WHOLE_W-1:0] whole_q;
  logic               q_full, q_valid, push, pop, accept;
  cmd_t               push_cmd, head_cmd;
  logic [TONE_W-1:0]  tone;
  logic [DUR_W-1:0]   duration;
  logic [IDX_W-1:0]   note_index;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !q_full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_tone_q <= BASE_TONE_RST;
      whole_q     <= WHOLE_RST;
    end else if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_BASE_TONE: base_tone_q <= cfg_data_i[TONE_W-1:0];
        REG_WHOLE_DUR: whole_q     <= cfg_data_i[WHOLE_W-1:0];
        default: ;
      endcase
    end
  end

  rtp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .symbol_i    (s_axis_tdata),
    .start_i     (s_axis_tuser),
    .base_tone_i (base_tone_q),
    .whole_i     (whole_q),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  rtp_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .head_o     (head_cmd)
  );

  rtp_back #(
    .NOTE_DEPTH (NOTE_DEPTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (q_valid),
    .cmd_i          (head_cmd),
    .pop_o          (pop),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .tone_o         (tone),
    .duration_o     (duration),
    .note_index_o   (note_index),
    .length_error_o (m_axis_tuser)
  );

  assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, note_index, duration, tone};

endmodule

@@ sv/rtp_checker.sv @@
module rtp_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [rtp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                            m_axis_tuser
);
  import rtp_pkg::*;

  localparam int unsigned DUR_LO = TONE_W;
  localparam int unsigned DUR_HI = TONE_W + DUR_W - 1;
  localparam int unsigned PAD_LO = TONE_W + DUR_W + IDX_W;

  a_hold_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result request changed");

  a_no_result_in_reset: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("result valid after reset");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[OUT_TDATA_W-1:PAD_LO] == '0)
    else $error("padding bits of result set");

  a_dur_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[DUR_HI:DUR_LO] <= DUR_MAX)
    else $error("duration out of range");

endmodule

bind ringtone_text_note_parser_unit rtp_checker u_rtp_checker (.*);
